// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each check samples on the rising edge of clk_i and is idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CHK(label, (ante) |-> (cons), msg)

`endif

// ===== design/cmrc_pkg.sv =====
package cmrc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HUMID_LOW     = 3'd0,
    REG_HUMID_NOMINAL = 3'd1,
    REG_HUMID_HIGH    = 3'd2,
    REG_TEMP_LOW      = 3'd3,
    REG_TEMP_NOMINAL  = 3'd4,
    REG_TEMP_HIGH     = 3'd5
  } reg_idx_e;

  // Operating modes
  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_DAY_DRY     = 3'd1,
    MODE_DAY_HUMID   = 3'd2,
    MODE_DAY_HOT     = 3'd3,
    MODE_DAY_COLD    = 3'd4,
    MODE_NIGHT_DRY   = 3'd5,
    MODE_NIGHT_HUMID = 3'd6,
    MODE_NIGHT_COLD  = 3'd7
  } mode_e;

  // Reset values of the thresholds
  localparam logic [6:0]        HumidLowRst     = 7'd40;
  localparam logic [6:0]        HumidNominalRst = 7'd55;
  localparam logic [6:0]        HumidHighRst    = 7'd70;
  localparam logic signed [7:0] TempLowRst      = 8'sd20;
  localparam logic signed [7:0] TempNominalRst  = 8'sd24;
  localparam logic signed [7:0] TempHighRst     = 8'sd28;

  // One reading
  typedef struct packed {
    logic              is_night;
    logic [6:0]        humidity;
    logic signed [7:0] temperature;
  } in_t;

  // One result
  typedef struct packed {
    logic [2:0] reported_mode;
    logic [2:0] next_mode;
    logic       light_on;
    logic       fan_on;
    logic       humidifier_on;
    logic       heater_on;
  } out_t;

  // Relay bank, light in the low bit
  typedef struct packed {
    logic heater;
    logic humidifier;
    logic fan;
    logic light;
  } relay_t;

  // Threshold set
  typedef struct packed {
    logic [6:0]        humid_low;
    logic [6:0]        humid_nominal;
    logic [6:0]        humid_high;
    logic signed [7:0] temp_low;
    logic signed [7:0] temp_nominal;
    logic signed [7:0] temp_high;
  } cfg_t;

endpackage

// ===== design/cmrc_step.sv =====
// Mode and relay update for one reading.
module cmrc_step
  import cmrc_pkg::*;
(
  input  cfg_t   cfg_i,
  input  in_t    item_i,
  input  mode_e  mode_i,
  input  relay_t relay_i,
  output mode_e  mode_o,
  output relay_t relay_o
);

  logic h_lt_low, h_lt_nom, h_gt_nom, h_gt_high;
  logic t_lt_low, t_lt_nom, t_gt_nom, t_gt_high;

  // Threshold compares: humidity unsigned, temperature signed
  assign h_lt_low  = item_i.humidity < cfg_i.humid_low;
  assign h_lt_nom  = item_i.humidity < cfg_i.humid_nominal;
  assign h_gt_nom  = item_i.humidity > cfg_i.humid_nominal;
  assign h_gt_high = item_i.humidity > cfg_i.humid_high;
  assign t_lt_low  = $signed(item_i.temperature) < $signed(cfg_i.temp_low);
  assign t_lt_nom  = $signed(item_i.temperature) < $signed(cfg_i.temp_nominal);
  assign t_gt_nom  = $signed(item_i.temperature) > $signed(cfg_i.temp_nominal);
  assign t_gt_high = $signed(item_i.temperature) > $signed(cfg_i.temp_high);

  // Rule table; light follows day/night, other relays hold where no rule fires
  always_comb begin
    mode_o        = mode_i;
    relay_o       = relay_i;
    relay_o.light = ~item_i.is_night;
    if (item_i.is_night) begin
      case (mode_i)
        MODE_IDLE: begin
          if (h_lt_low) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b1; relay_o.heater = 1'b0;
            mode_o = MODE_NIGHT_DRY;
          end else if (h_gt_high) begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b0; relay_o.heater = 1'b1;
            mode_o = MODE_NIGHT_HUMID;
          end else if (t_lt_nom) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b0; relay_o.heater = 1'b1;
            mode_o = MODE_NIGHT_COLD;
          end else begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b0; relay_o.heater = 1'b0;
          end
        end
        MODE_NIGHT_DRY: begin
          if (h_gt_nom) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b0; relay_o.heater = 1'b0;
            mode_o = MODE_IDLE;
          end
        end
        MODE_NIGHT_HUMID: begin
          if (h_lt_nom) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b0; relay_o.heater = 1'b0;
            mode_o = MODE_IDLE;
          end
        end
        MODE_NIGHT_COLD: begin
          if (!t_lt_nom) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b0; relay_o.heater = 1'b0;
            mode_o = MODE_IDLE;
          end
        end
        default: begin
          // day mode seen at night
          relay_o.fan = 1'b0; relay_o.humidifier = 1'b0; relay_o.heater = 1'b0;
          mode_o = MODE_IDLE;
        end
      endcase
    end else begin
      case (mode_i)
        MODE_IDLE: begin
          if (h_lt_nom) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b1; relay_o.heater = 1'b0;
            mode_o = MODE_DAY_DRY;
          end else if (h_gt_high) begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b0; relay_o.heater = 1'b1;
            mode_o = MODE_DAY_HUMID;
          end else if (t_gt_high) begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b1; relay_o.heater = 1'b0;
            mode_o = MODE_DAY_HOT;
          end else if (t_lt_low) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
            mode_o = MODE_DAY_COLD;
          end else begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
          end
        end
        MODE_DAY_DRY: begin
          if (t_gt_nom) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b1; relay_o.heater = 1'b0;
          end else if (t_lt_nom) begin
            relay_o.fan = 1'b0; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
          end
          if (!h_lt_nom) begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
            mode_o = MODE_IDLE;
          end
        end
        MODE_DAY_HUMID: begin
          if (h_lt_nom) begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
            mode_o = MODE_IDLE;
          end
        end
        MODE_DAY_HOT: begin
          if (t_lt_nom) begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
            mode_o = MODE_DAY_DRY;
          end
        end
        MODE_DAY_COLD: begin
          if (t_gt_nom) begin
            relay_o.fan = 1'b1; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
            mode_o = MODE_IDLE;
          end
        end
        default: begin
          // night mode seen by day
          relay_o.fan = 1'b1; relay_o.humidifier = 1'b1; relay_o.heater = 1'b1;
          mode_o = MODE_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/climate_mode_relay_controller_top.sv =====
// Climate mode relay controller. Each input transaction is one reading
// (day/night flag, humidity, temperature); each produces exactly one result
// transaction with the mode before the reading, the mode after it and the four
// relay states. One reading is accepted per clock cycle unless the input is
// stalled. A reading passes from the input register to the result register,
// from which its result is offered. A stalled result holds the reading
// behind it, so the input stalls only while both registers are full. The
// mode and relay registers are updated in the result stage, so each reading
// sees the state left by the one before it. Thresholds reset to 40/55/70 %RH
// and 20/24/28 C, are written through the configuration port (always ready),
// and must only be changed while no reading is in flight.
module climate_mode_relay_controller_top
  import cmrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // reading channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t   cfg_q;
  in_t    in_q;
  logic   in_valid_q;
  out_t   out_q;
  logic   out_valid_q;
  mode_e  mode_q, mode_d;
  relay_t relay_q, relay_d;
  logic   advance;

  assign cfg_ready_o = 1'b1;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.humid_low     <= HumidLowRst;
      cfg_q.humid_nominal <= HumidNominalRst;
      cfg_q.humid_high    <= HumidHighRst;
      cfg_q.temp_low      <= TempLowRst;
      cfg_q.temp_nominal  <= TempNominalRst;
      cfg_q.temp_high     <= TempHighRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HUMID_LOW:     cfg_q.humid_low     <= cfg_data_i[6:0];
        REG_HUMID_NOMINAL: cfg_q.humid_nominal <= cfg_data_i[6:0];
        REG_HUMID_HIGH:    cfg_q.humid_high    <= cfg_data_i[6:0];
        REG_TEMP_LOW:      cfg_q.temp_low      <= $signed(cfg_data_i);
        REG_TEMP_NOMINAL:  cfg_q.temp_nominal  <= $signed(cfg_data_i);
        REG_TEMP_HIGH:     cfg_q.temp_high     <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Result stage moves when the result register is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  cmrc_step u_step (
    .cfg_i   (cfg_q),
    .item_i  (in_q),
    .mode_i  (mode_q),
    .relay_i (relay_q),
    .mode_o  (mode_d),
    .relay_o (relay_d)
  );

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      relay_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        mode_q  <= mode_d;
        relay_q <= relay_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q.reported_mode <= mode_q;
      out_q.next_mode     <= mode_d;
      out_q.light_on      <= relay_d.light;
      out_q.fan_on        <= relay_d.fan;
      out_q.humidifier_on <= relay_d.humidifier;
      out_q.heater_on     <= relay_d.heater;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/cmrc_checker.sv =====
`include "assert_macros.svh"

// Port-level checks on the result stream.
module cmrc_checker
  import cmrc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic [2:0] last_mode_q;
  logic       out_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;

  // Mode left behind by the last delivered transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_mode_q <= MODE_IDLE;
    end else if (out_xfer) begin
      last_mode_q <= out_data_o.next_mode;
    end
  end

  // stalled result holds
  `ASSERT_CHK(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)), "result changed while stalled")

  // results chain: each starts from the mode the previous one ended in
  `ASSERT_IMPL(a_mode_chain, out_valid_o, out_data_o.reported_mode == last_mode_q, "mode chain broken")

  // night modes drive light off, day modes drive light on
  `ASSERT_IMPL(a_night_light, out_valid_o && (out_data_o.next_mode >= MODE_NIGHT_DRY), !out_data_o.light_on, "light on in night mode")
  `ASSERT_IMPL(a_day_light, out_valid_o && (out_data_o.next_mode != MODE_IDLE) && (out_data_o.next_mode <= MODE_DAY_COLD), out_data_o.light_on, "light off in day mode")

  // no direct jump from a day mode into a night mode
  `ASSERT_IMPL(a_no_cross, out_valid_o && (out_data_o.next_mode >= MODE_NIGHT_DRY), (out_data_o.reported_mode == MODE_IDLE) || (out_data_o.reported_mode == out_data_o.next_mode), "night mode entered from a day mode")

endmodule

bind climate_mode_relay_controller_top cmrc_checker u_cmrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
